[rtl/core/u8ss_pkg.sv]
// Shared types, constants and byte-class helpers for the UTF-8 stream sanitizer.
// No dependencies; used by the decoder, out_buf and core through scoped names.
`timescale 1ns / 1ps

package u8ss_pkg;

  // Replacement byte for anything that cannot be passed on ('?')
  localparam logic [7:0] SubChar = 8'h3F;

  // Byte-class masks and patterns
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContPat   = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] AsciiTop  = 8'h80;

  // Number of bytes held back while a multi-byte sequence is incomplete
  typedef enum logic [1:0] {
    HELD_NONE      = 2'd0,
    HELD_LEAD      = 2'd1,
    HELD_LEAD_CONT = 2'd2
  } held_cnt_e;

  // Pending-sequence state
  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] cont;
    held_cnt_e  count;
  } held_t;

  // Results of one input byte: up to three bytes, first in slot 0
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      num;
    logic            last;
  } res_t;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & ContMask) == ContPat;
  endfunction

  function automatic logic is_lead2(input logic [7:0] b);
    return (b & Lead2Mask) == Lead2Pat;
  endfunction

  function automatic logic is_lead3(input logic [7:0] b);
    return (b & Lead3Mask) == Lead3Pat;
  endfunction

endpackage

[rtl/core/u8ss_decode.sv]
// Combinational byte classifier: turns one input byte and the pending state
// into up to three result bytes and the next pending state. Uses u8ss_pkg.
`timescale 1ns / 1ps

module u8ss_decode (
  input  u8ss_pkg::held_t held_i,
  input  logic [7:0]      byte_i,
  input  logic            last_i,
  output u8ss_pkg::res_t  res_o,
  output u8ss_pkg::held_t held_o
);

  always_comb begin
    logic            consumed;
    logic [1:0]      num;
    logic [2:0][7:0] bytes;
    u8ss_pkg::held_t nxt;

    consumed = 1'b0;
    num      = 2'd0;
    bytes    = {3{u8ss_pkg::SubChar}};
    nxt      = held_i;

    // Resolve a pending sequence against the new byte
    unique case (held_i.count)
      u8ss_pkg::HELD_LEAD, u8ss_pkg::HELD_LEAD_CONT: begin
        if (u8ss_pkg::is_cont(byte_i)) begin
          consumed = 1'b1;
          if (held_i.count == u8ss_pkg::HELD_LEAD && u8ss_pkg::is_lead2(held_i.lead)) begin
            bytes[0]  = held_i.lead;
            bytes[1]  = byte_i;
            num       = 2'd2;
            nxt.count = u8ss_pkg::HELD_NONE;
          end else if (held_i.count == u8ss_pkg::HELD_LEAD) begin
            nxt.cont  = byte_i;
            nxt.count = u8ss_pkg::HELD_LEAD_CONT;
          end else begin
            bytes[0]  = held_i.lead;
            bytes[1]  = held_i.cont;
            bytes[2]  = byte_i;
            num       = 2'd3;
            nxt.count = u8ss_pkg::HELD_NONE;
          end
        end else begin
          // Broken sequence: each held byte becomes '?'
          num       = 2'(held_i.count);
          nxt.count = u8ss_pkg::HELD_NONE;
        end
      end
      default: begin
        nxt.count = u8ss_pkg::HELD_NONE;
      end
    endcase

    // Examine the byte as a fresh start
    if (!consumed) begin
      priority if (byte_i < u8ss_pkg::AsciiTop) begin
        bytes[num] = byte_i;
        num        = num + 2'd1;
      end else if (u8ss_pkg::is_lead2(byte_i) || u8ss_pkg::is_lead3(byte_i)) begin
        nxt.lead  = byte_i;
        nxt.count = u8ss_pkg::HELD_LEAD;
      end else begin
        num = num + 2'd1;
      end
    end

    // End of text: flush anything still held as '?'
    if (last_i) begin
      num       = num + 2'(nxt.count);
      nxt.count = u8ss_pkg::HELD_NONE;
    end

    res_o.bytes = bytes;
    res_o.num   = num;
    res_o.last  = last_i;
    held_o      = nxt;
  end

endmodule

[rtl/core/u8ss_out_buf.sv]
// Result register: holds the up-to-three bytes of one input item and hands
// them out one transfer per cycle while the master is ready. Uses u8ss_pkg.
`timescale 1ns / 1ps

module u8ss_out_buf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  u8ss_pkg::res_t res_i,
  output logic           can_load_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [7:0]     m_axis_tdata_o,   // [7:0] clean_byte
  output logic           m_axis_tlast_o    // last_out
);

  logic [2:0][7:0] bytes_q, bytes_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            last_q, last_d;
  logic            pop;

  assign pop        = (cnt_q != 2'd0) && m_axis_tready_i;
  assign can_load_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready_i);

  // Load a fresh burst or shift the next byte down on each transfer
  always_comb begin
    bytes_d = bytes_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    if (load_i) begin
      bytes_d = res_i.bytes;
      cnt_d   = res_i.num;
      last_d  = res_i.last;
    end else if (pop) begin
      bytes_d = {u8ss_pkg::SubChar, bytes_q[2], bytes_q[1]};
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      last_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
  end

  assign m_axis_tvalid_o = cnt_q != 2'd0;
  assign m_axis_tdata_o  = bytes_q[0];
  assign m_axis_tlast_o  = last_q && (cnt_q == 2'd1);

endmodule

[rtl/core/utf8_stream_sanitizer_core.sv]
// UTF-8 stream sanitizer top level: input register, pending-sequence state,
// decoder and result register. Uses u8ss_pkg, u8ss_decode, u8ss_out_buf.
`timescale 1ns / 1ps
//
// Usage
//   Slave stream carries raw text bytes, tlast on the final byte of a text.
//   Master stream carries cleaned bytes; tlast marks the final output byte
//   of a text. Valid 2- and 3-byte sequences are emitted whole once complete,
//   ASCII passes straight through, everything else becomes '?'.
// Path
//   The first result of an item passes through the input register and then
//   the result register before it appears on the master stream.
// Throughput
//   One item per cycle while each item yields at most one byte and the
//   master side is ready. An item that yields more bytes (up to 3) holds
//   the master port for one transfer per byte; a lead byte that is held
//   yields none. The single-ported result register sets this limit.
// Reset
//   Empties the input and result registers and drops any pending sequence.
// Stall
//   When the master side stalls, the result register holds its bytes, the
//   input register holds one more item, and s_axis_tready_o then drops.
//
module utf8_stream_sanitizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tlast_i,   // is_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] clean_byte
  output logic       m_axis_tlast_o    // last_out
);

  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  u8ss_pkg::held_t held_q, held_d;
  u8ss_pkg::res_t  res;
  logic            can_load;
  logic            load;
  logic            s_xfer;

  assign load            = in_valid_q && can_load;
  assign s_axis_tready_o = !in_valid_q || load;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  // Input register: fill on transfer, empty when the item is decoded
  always_comb begin
    in_valid_d = in_valid_q;
    if (s_xfer) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  u8ss_decode u_decode (
    .held_i (held_q),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res),
    .held_o (held_d)
  );

  // Advance the pending-sequence state when an item is decoded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '{lead: 8'h00, cont: 8'h00, count: u8ss_pkg::HELD_NONE};
    end else if (load) begin
      held_q <= held_d;
    end
  end

  u8ss_out_buf u_out_buf (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .res_i           (res),
    .can_load_o      (can_load),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

[rtl/core/u8ss_checker.sv]
// Port-level checker for utf8_stream_sanitizer_core, attached by bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module u8ss_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  // A stalled output transfer stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output valid dropped while stalled");

  // A stalled output transfer keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output payload changed while stalled");

  // Input is only held off while a result waits on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with no output pending");

  // No 4-byte lead or invalid high byte ever leaves the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[7:3] != 5'b11110) && (m_axis_tdata_o[7:3] != 5'b11111))
    else $error("forbidden byte on output");

endmodule

bind utf8_stream_sanitizer_core u8ss_checker u_u8ss_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
